// ===== sv/cpr_pkg.sv =====
// Shared types and constants for the clock page replacement engine.
// Used by cpr_marks, cpr_page_ram, cpr_seq and clock_page_replacement_top.
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int PAGE_BITS_DEF  = 20;

  localparam int SLOT_IDX_W = 6;
  localparam int PAGE_IN_W  = 20;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_DATA_W-1:0] WS_LIMIT_RESET = 7'd64;

  typedef enum logic {
    REG_POLICY_MODE = 1'b0,
    REG_WS_LIMIT    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ACT_ACCESS = 1'b0,
    ACT_FAULT  = 1'b1
  } action_t;

  typedef enum logic {
    POLICY_PLAIN    = 1'b0,
    POLICY_ENHANCED = 1'b1
  } policy_t;

  typedef enum logic [1:0] {
    OUT_ACCESS   = 2'd0,
    OUT_FILLED   = 2'd1,
    OUT_REPLACED = 2'd2,
    OUT_IGNORED  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic set_used;
    logic set_mod;
    logic clr_used;
    logic clr_both;
  } mark_cmd_t;

endpackage

`default_nettype wire

// ===== sv/cpr_marks.sv =====
// Used and modified mark flops for every slot, one read/update address per cycle.
// Depends on cpr_pkg (mark_cmd_t).
`timescale 1ns / 1ps
`default_nettype none

module cpr_marks #(
  parameter int SLOT_COUNT = cpr_pkg::SLOT_COUNT_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire [$clog2(SLOT_COUNT)-1:0] addr,
  input  cpr_pkg::mark_cmd_t           cmd,
  output logic                         used_rd,
  output logic                         mod_rd
);
  import cpr_pkg::*;

  logic [SLOT_COUNT-1:0] used;
  logic [SLOT_COUNT-1:0] modified;

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      modified <= '0;
    end else begin
      if (cmd.set_used) used[addr] <= 1'b1;
      if (cmd.clr_used || cmd.clr_both) used[addr] <= 1'b0;
      if (cmd.set_mod) modified[addr] <= 1'b1;
      if (cmd.clr_both) modified[addr] <= 1'b0;
    end
  end

  assign used_rd = used[addr];
  assign mod_rd  = modified[addr];

endmodule

`default_nettype wire

// ===== sv/cpr_page_ram.sv =====
// Single-port page store, one entry per slot, registered read.
// No dependencies beyond cpr_pkg defaults.
`timescale 1ns / 1ps
`default_nettype none

module cpr_page_ram #(
  parameter int DEPTH = cpr_pkg::SLOT_COUNT_DEF,
  parameter int WIDTH = cpr_pkg::PAGE_BITS_DEF
) (
  input  wire                     clk,
  input  wire [$clog2(DEPTH)-1:0] addr,
  input  wire                     we,
  input  wire [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]        rdata
);
  import cpr_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== sv/cpr_seq.sv =====
// Request sequencer: access and fill in one step, replacement sweep one slot per cycle.
// Depends on cpr_pkg; drives cpr_marks and cpr_page_ram.
`timescale 1ns / 1ps
`default_nettype none

module cpr_seq #(
  parameter int SLOT_COUNT = cpr_pkg::SLOT_COUNT_DEF,
  parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire                                action,
  input  wire [cpr_pkg::SLOT_IDX_W-1:0]      slot_index,
  input  wire                                is_write,
  input  wire [cpr_pkg::PAGE_IN_W-1:0]       page_number,
  input  wire                                policy_mode,
  input  wire [cpr_pkg::CFG_DATA_W-1:0]      working_set_limit,
  output logic                               busy,
  output logic                               done,
  output cpr_pkg::outcome_t                  outcome,
  output logic [cpr_pkg::SLOT_IDX_W-1:0]     chosen_slot,
  output logic [cpr_pkg::PAGE_IN_W-1:0]      evicted_page,
  output logic                               writeback_needed,
  output logic [$clog2(SLOT_COUNT)-1:0]      mark_addr,
  output cpr_pkg::mark_cmd_t                 mark_cmd,
  input  wire                                used_rd,
  input  wire                                mod_rd,
  output logic [$clog2(SLOT_COUNT)-1:0]      ram_addr,
  output logic                               ram_we,
  output logic [PAGE_BITS-1:0]               ram_wdata,
  input  wire  [PAGE_BITS-1:0]               ram_rdata
);
  import cpr_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int W  = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

  state_t         state, state_next;
  logic [SW-1:0]  pos, pos_next;
  logic [CW-1:0]  k, k_next;
  logic           phase_b, phase_b_next;
  logic [SW-1:0]  hand, hand_next;
  logic [CW-1:0]  filled, filled_next;
  logic [PAGE_BITS-1:0] page_hold;

  logic                  done_next;
  outcome_t              outcome_next;
  logic [SLOT_IDX_W-1:0] chosen_next;
  logic [PAGE_IN_W-1:0]  evict_next;
  logic                  wb_next;

  logic [W-1:0]  lim, slot_ext, filled_ext;
  logic          slot_ok, has_free, need_sweep, accept, last_step;
  logic [SW-1:0] pos_inc, sweep_start;

  always_comb begin
    lim = W'(working_set_limit);
    if (lim == '0) lim = W'(1);
    if (lim > W'(SLOT_COUNT)) lim = W'(SLOT_COUNT);
  end

  assign slot_ext    = W'(slot_index);
  assign filled_ext  = W'(filled);
  assign slot_ok     = slot_ext < filled_ext;
  assign has_free    = filled_ext < lim;
  assign accept      = start && !busy;
  assign need_sweep  = (action == ACT_FAULT) && !has_free;
  assign pos_inc     = ((CW'(pos) + CW'(1)) >= filled) ? '0 : pos + SW'(1);
  assign sweep_start = (CW'(hand) < filled) ? hand : '0;
  assign last_step   = (k == filled - CW'(1));
  assign busy        = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pos     <= '0;
      k       <= '0;
      phase_b <= 1'b0;
      hand    <= '0;
      filled  <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      k       <= k_next;
      phase_b <= phase_b_next;
      hand    <= hand_next;
      filled  <= filled_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) page_hold <= PAGE_BITS'(page_number);
    outcome          <= outcome_next;
    chosen_slot      <= chosen_next;
    evicted_page     <= evict_next;
    writeback_needed <= wb_next;
  end

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    k_next       = k;
    phase_b_next = phase_b;
    hand_next    = hand;
    filled_next  = filled;
    mark_addr    = pos;
    mark_cmd     = '0;
    ram_addr     = pos;
    ram_we       = 1'b0;
    ram_wdata    = page_hold;
    done_next    = 1'b0;
    outcome_next = OUT_ACCESS;
    chosen_next  = SLOT_IDX_W'(pos);
    evict_next   = '0;
    wb_next      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (action == ACT_ACCESS) begin
            mark_addr   = slot_ext[SW-1:0];
            done_next   = 1'b1;
            chosen_next = slot_index;
            if (slot_ok) begin
              mark_cmd.set_used = 1'b1;
              mark_cmd.set_mod  = is_write;
              outcome_next      = OUT_ACCESS;
            end else begin
              outcome_next = OUT_IGNORED;
            end
          end else if (has_free) begin
            ram_addr          = filled[SW-1:0];
            ram_we            = 1'b1;
            ram_wdata         = PAGE_BITS'(page_number);
            mark_addr         = filled[SW-1:0];
            mark_cmd.clr_both = 1'b1;
            filled_next       = filled + CW'(1);
            done_next         = 1'b1;
            outcome_next      = OUT_FILLED;
            chosen_next       = SLOT_IDX_W'(filled);
          end else begin
            pos_next     = sweep_start;
            k_next       = '0;
            phase_b_next = 1'b0;
            state_next   = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (policy_mode == POLICY_PLAIN) begin
          if (!used_rd) begin
            state_next = ST_RESULT;
          end else begin
            mark_cmd.clr_used = 1'b1;
            pos_next          = pos_inc;
          end
        end else if (!phase_b) begin
          if (!used_rd && !mod_rd) begin
            state_next = ST_RESULT;
          end else begin
            pos_next = pos_inc;
            k_next   = last_step ? '0 : k + CW'(1);
            if (last_step) phase_b_next = 1'b1;
          end
        end else begin
          if (!used_rd) begin
            state_next = ST_RESULT;
          end else begin
            mark_cmd.clr_used = 1'b1;
            pos_next          = pos_inc;
            k_next            = last_step ? '0 : k + CW'(1);
            if (last_step) phase_b_next = 1'b0;
          end
        end
      end
      ST_RESULT: begin
        ram_we            = 1'b1;
        mark_cmd.clr_both = 1'b1;
        done_next         = 1'b1;
        outcome_next      = OUT_REPLACED;
        evict_next        = PAGE_IN_W'(ram_rdata);
        wb_next           = mod_rd;
        hand_next         = pos_inc;
        state_next        = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= CW'(SLOT_COUNT))
    else $error("fill count beyond slot count");

  a_sweep_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (CW'(pos) < filled))
    else $error("sweep position outside ring");

  a_replace_src: assert property (@(posedge clk) disable iff (rst)
    (done && outcome == OUT_REPLACED) |-> ($past(state) == ST_RESULT))
    else $error("replacement result without write-back step");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !need_sweep) |=> done)
    else $error("single-step request gave no result");
`endif

endmodule

`default_nettype wire

// ===== sv/clock_page_replacement_top.sv =====
// Access and free-slot fill give their result in the cycle after the request is taken.
// A replacement sweeps the mark unit one slot per cycle, then writes the new page
// in its write step (ST_RESULT); the result comes the cycle after.
// busy is high from the sweep through the write step; single-step requests may be issued every cycle while busy is low.
// Synchronous reset clears marks, fill count, hand, state, config; not page store or results.
// Results cannot be stalled: done marks each result for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module clock_page_replacement_top #(
  parameter int SLOT_COUNT = cpr_pkg::SLOT_COUNT_DEF,
  parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire                            cfg_index,
  input  wire [cpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                            start,
  output logic                           busy,
  input  wire                            action,
  input  wire [cpr_pkg::SLOT_IDX_W-1:0]  slot_index,
  input  wire                            is_write,
  input  wire [cpr_pkg::PAGE_IN_W-1:0]   page_number,
  output logic                           done,
  output cpr_pkg::outcome_t              outcome,
  output logic [cpr_pkg::SLOT_IDX_W-1:0] chosen_slot,
  output logic [cpr_pkg::PAGE_IN_W-1:0]  evicted_page,
  output logic                           writeback_needed
);
  import cpr_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);

  logic                  policy_mode;
  logic [CFG_DATA_W-1:0] working_set_limit;

  logic [SW-1:0]        mark_addr;
  mark_cmd_t            mark_cmd;
  logic                 used_rd, mod_rd;
  logic [SW-1:0]        ram_addr;
  logic                 ram_we;
  logic [PAGE_BITS-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode       <= POLICY_PLAIN;
      working_set_limit <= WS_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POLICY_MODE: policy_mode       <= cfg_data[0];
        REG_WS_LIMIT:    working_set_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  cpr_seq #(
    .SLOT_COUNT(SLOT_COUNT),
    .PAGE_BITS (PAGE_BITS)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .action           (action),
    .slot_index       (slot_index),
    .is_write         (is_write),
    .page_number      (page_number),
    .policy_mode      (policy_mode),
    .working_set_limit(working_set_limit),
    .busy             (busy),
    .done             (done),
    .outcome          (outcome),
    .chosen_slot      (chosen_slot),
    .evicted_page     (evicted_page),
    .writeback_needed (writeback_needed),
    .mark_addr        (mark_addr),
    .mark_cmd         (mark_cmd),
    .used_rd          (used_rd),
    .mod_rd           (mod_rd),
    .ram_addr         (ram_addr),
    .ram_we           (ram_we),
    .ram_wdata        (ram_wdata),
    .ram_rdata        (ram_rdata)
  );

  cpr_marks #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_marks (
    .clk    (clk),
    .rst    (rst),
    .addr   (mark_addr),
    .cmd    (mark_cmd),
    .used_rd(used_rd),
    .mod_rd (mod_rd)
  );

  cpr_page_ram #(
    .DEPTH(SLOT_COUNT),
    .WIDTH(PAGE_BITS)
  ) u_pages (
    .clk  (clk),
    .addr (ram_addr),
    .we   (ram_we),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

endmodule

`default_nettype wire
